### hw/rtl/rle_pkg.sv
// Shared types and constants for the run-length byte stream encoder.
// Depends on nothing; every other file imports it.
package rle_pkg;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  localparam logic [15:0] MaxCountOne = 16'h00FF;
  localparam logic [15:0] MaxCountTwo = 16'hFFFF;

  localparam int unsigned PaddrW = 3;
  localparam int unsigned PdataW = 32;

  // Register index, taken from paddr[2]
  localparam logic RegCountMode = 1'b0;

  // At most one command per item: the run it closes, then the run it flushes.
  typedef struct packed {
    logic        closed_vld;
    logic [7:0]  closed_val;
    logic [15:0] closed_len;
    logic        flush_vld;
    logic [7:0]  flush_val;
    logic [15:0] flush_len;
    logic        two_bytes;
  } rle_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } rle_fifo_status_t;

  typedef enum logic [2:0] {
    PhClosedLo,
    PhClosedHi,
    PhClosedVal,
    PhFlushLo,
    PhFlushHi,
    PhFlushVal
  } rle_phase_e;

endpackage

### hw/rtl/rle_byte_stream_encoder.sv
// Top level of the run-length byte stream encoder: mode register, front end,
// command queue and back end. Depends on rle_pkg, rle_front, rle_fifo, rle_back.

// Each run leaves as its count (one byte, or two bytes low first when
// count_two_bytes is set) followed by its data byte. An input word is taken
// in the cycle it is offered as long as the four-entry command queue has room;
// a word that only lengthens the open run produces nothing, one that closes a
// run produces two or three output words, and a last_in_block word up to six.
// Output runs at one word per cycle, while the receiver is ready, from a single
// registered stage; the first output word of an item passes through the command
// queue and then the output register.
module rle_byte_stream_encoder (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [7:0]                 data_byte_i,
  input  logic                       last_in_block_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [7:0]                 out_byte_o,
  output logic                       out_item_end_o,
  output logic                       out_block_end_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rle_pkg::PaddrW-1:0] paddr,
  input  logic [rle_pkg::PdataW-1:0] pwdata,
  output logic [rle_pkg::PdataW-1:0] prdata,
  output logic                       pready
);
  import rle_pkg::*;

  logic             count_two_bytes_q, count_two_bytes_d;
  logic             reg_hit;
  logic             cmd_valid;
  rle_cmd_t         cmd;
  rle_cmd_t         head;
  rle_fifo_status_t fifo_status;
  logic             pop;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == RegCountMode);

  always_comb begin
    count_two_bytes_d = count_two_bytes_q;
    if (psel && penable && pwrite && reg_hit) begin
      count_two_bytes_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_two_bytes_q <= 1'b1;
    end else begin
      count_two_bytes_q <= count_two_bytes_d;
    end
  end

  assign prdata = reg_hit ? {{(PdataW-1){1'b0}}, count_two_bytes_q} : '0;

  rle_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .data_byte_i       (data_byte_i),
    .last_in_block_i   (last_in_block_i),
    .count_two_bytes_i (count_two_bytes_q),
    .cmd_ready_i       (!fifo_status.full),
    .cmd_valid_o       (cmd_valid),
    .cmd_o             (cmd)
  );

  rle_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (cmd_valid),
    .push_data_i (cmd),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (fifo_status)
  );

  rle_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_valid_i    (!fifo_status.empty),
    .head_i          (head),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_byte_o      (out_byte_o),
    .out_item_end_o  (out_item_end_o),
    .out_block_end_o (out_block_end_o)
  );

endmodule

### hw/rtl/rle_front.sv
// Front end: accepts words, tracks the open run and classifies each item
// into a run command for the queue. Depends on rle_pkg.
module rle_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       data_byte_i,
  input  logic             last_in_block_i,
  input  logic             count_two_bytes_i,
  input  logic             cmd_ready_i,
  output logic             cmd_valid_o,
  output rle_pkg::rle_cmd_t cmd_o
);
  import rle_pkg::*;

  logic [7:0]  run_value_q, run_value_d;
  logic [15:0] run_length_q, run_length_d;
  logic        run_open_q, run_open_d;

  logic        accept;
  logic        extend;
  logic [15:0] max_len;
  logic [15:0] new_len;
  logic [15:0] closed_len;

  assign in_ready_o = cmd_ready_i;
  assign accept     = in_valid_i && cmd_ready_i;
  assign max_len    = count_two_bytes_i ? MaxCountTwo : MaxCountOne;

  assign extend  = run_open_q && (data_byte_i == run_value_q) && (run_length_q < max_len);
  assign new_len = extend ? (run_length_q + 16'd1) : 16'd1;

  // A run left over from two-byte mode saturates when written as one byte.
  assign closed_len = (!count_two_bytes_i && (run_length_q > MaxCountOne)) ?
                      MaxCountOne : run_length_q;

  always_comb begin
    cmd_o.closed_vld = run_open_q && !extend;
    cmd_o.closed_val = run_value_q;
    cmd_o.closed_len = closed_len;
    cmd_o.flush_vld  = last_in_block_i;
    cmd_o.flush_val  = data_byte_i;
    cmd_o.flush_len  = new_len;
    cmd_o.two_bytes  = count_two_bytes_i;
  end

  assign cmd_valid_o = accept && ((run_open_q && !extend) || last_in_block_i);

  always_comb begin
    run_value_d  = run_value_q;
    run_length_d = run_length_q;
    run_open_d   = run_open_q;
    if (accept) begin
      if (last_in_block_i) begin
        run_value_d  = 8'd0;
        run_length_d = 16'd0;
        run_open_d   = 1'b0;
      end else begin
        run_value_d  = data_byte_i;
        run_length_d = new_len;
        run_open_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_value_q  <= 8'd0;
      run_length_q <= 16'd0;
      run_open_q   <= 1'b0;
    end else begin
      run_value_q  <= run_value_d;
      run_length_q <= run_length_d;
      run_open_q   <= run_open_d;
    end
  end

endmodule

### hw/rtl/rle_fifo.sv
// Short command queue between the front and back ends.
// Depends on rle_pkg.
module rle_fifo (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  rle_pkg::rle_cmd_t         push_data_i,
  input  logic                      pop_i,
  output rle_pkg::rle_cmd_t         head_o,
  output rle_pkg::rle_fifo_status_t status_o
);
  import rle_pkg::*;

  rle_cmd_t            mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FifoCntW-1:0] count_q, count_d;
  logic                do_push, do_pop;

  assign status_o.full  = (count_q == FifoCntW'(FifoDepth));
  assign status_o.empty = (count_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + FifoPtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + FifoPtrW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + FifoCntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - FifoCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

### hw/rtl/rle_back.sv
// Back end: walks each queued command one encoded word per cycle, while the output
// is not stalled, into the output register. Depends on rle_pkg.
module rle_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  rle_pkg::rle_cmd_t head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_byte_o,
  output logic              out_item_end_o,
  output logic              out_block_end_o
);
  import rle_pkg::*;

  rle_phase_e phase_q, phase_d;
  rle_phase_e phase_eff;

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       item_end_q, item_end_d;
  logic       block_end_q, block_end_d;

  logic       load;
  logic [7:0] sel_byte;
  logic       sel_last;
  logic       sel_block_end;

  assign load = head_valid_i && (!out_valid_q || out_ready_i);

  // A command without a closed run starts straight at the flushed run.
  assign phase_eff = ((phase_q == PhClosedLo) && !head_i.closed_vld) ? PhFlushLo : phase_q;

  // Next state
  always_comb begin
    phase_d = phase_q;
    if (load) begin
      case (phase_eff)
        PhClosedLo:  phase_d = head_i.two_bytes ? PhClosedHi : PhClosedVal;
        PhClosedHi:  phase_d = PhClosedVal;
        PhClosedVal: phase_d = head_i.flush_vld ? PhFlushLo : PhClosedLo;
        PhFlushLo:   phase_d = head_i.two_bytes ? PhFlushHi : PhFlushVal;
        PhFlushHi:   phase_d = PhFlushVal;
        PhFlushVal:  phase_d = PhClosedLo;
        default:     phase_d = PhClosedLo;
      endcase
    end
  end

  // Outputs of the sequencer
  always_comb begin
    sel_byte      = 8'd0;
    sel_last      = 1'b0;
    sel_block_end = 1'b0;
    case (phase_eff)
      PhClosedLo:  sel_byte = head_i.closed_len[7:0];
      PhClosedHi:  sel_byte = head_i.closed_len[15:8];
      PhClosedVal: begin
        sel_byte = head_i.closed_val;
        sel_last = !head_i.flush_vld;
      end
      PhFlushLo:   sel_byte = head_i.flush_len[7:0];
      PhFlushHi:   sel_byte = head_i.flush_len[15:8];
      PhFlushVal:  begin
        sel_byte      = head_i.flush_val;
        sel_last      = 1'b1;
        sel_block_end = 1'b1;
      end
      default:     sel_byte = 8'd0;
    endcase
  end

  assign pop_o = load && sel_last;

  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    item_end_d  = item_end_q;
    block_end_d = block_end_q;
    if (load) begin
      out_valid_d = 1'b1;
      out_byte_d  = sel_byte;
      item_end_d  = sel_last;
      block_end_d = sel_block_end;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhClosedLo;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q  <= out_byte_d;
    item_end_q  <= item_end_d;
    block_end_q <= block_end_d;
  end

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = out_byte_q;
  assign out_item_end_o  = item_end_q;
  assign out_block_end_o = block_end_q;

endmodule

### hw/rtl/rle_checker.sv
// Port-level checks for the run-length byte stream encoder, bound to the top.
// Depends on rle_pkg and rle_byte_stream_encoder.
module rle_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [7:0]                 out_byte_o,
  input logic                       out_item_end_o,
  input logic                       out_block_end_o,
  input logic                       psel,
  input logic                       penable,
  input logic                       pwrite,
  input logic [rle_pkg::PaddrW-1:0] paddr,
  input logic [rle_pkg::PdataW-1:0] pwdata,
  input logic [rle_pkg::PdataW-1:0] prdata,
  input logic                       pready
);
  import rle_pkg::*;

  // A stalled output word keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(out_item_end_o) && $stable(out_block_end_o))
    else $error("output word changed while stalled");

  // The final word of a block is also the final word of its item.
  a_block_end_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_block_end_o |-> out_item_end_o)
    else $error("block end without item end");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready low");

  // A write to the mode register is visible on the next read of it.
  a_mode_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && (paddr[2] == RegCountMode)
      |=> (prdata[0] == $past(pwdata[0])) || (paddr[2] != RegCountMode)
        || (psel && penable && pwrite))
    else $error("mode register readback mismatch");

endmodule

bind rle_byte_stream_encoder rle_checker u_rle_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .out_byte_o      (out_byte_o),
  .out_item_end_o  (out_item_end_o),
  .out_block_end_o (out_block_end_o),
  .psel            (psel),
  .penable         (penable),
  .pwrite          (pwrite),
  .paddr           (paddr),
  .pwdata          (pwdata),
  .prdata          (prdata),
  .pready          (pready)
);

### tb/rle_byte_stream_encoder_tb.sv
// Self-checking testbench for the run-length byte stream encoder: a directed table,
// then random blocks, checked word by word against typed bytes or a behavioural encoder.
// Depends on rle_pkg and rle_byte_stream_encoder.
`timescale 1ns / 100ps

module rle_byte_stream_encoder_tb;
  import rle_pkg::*;

  localparam logic [PaddrW-1:0] AddrMode  = {RegCountMode, 2'b00};
  localparam logic [PaddrW-1:0] AddrSpare = {~RegCountMode, 2'b00};
  localparam int SettleCycles = 8;
  localparam int RandWords    = 80;

  typedef enum logic [1:0] {RowWord, RowRun, RowReg} row_kind_e;

  // One line of the directed table. A negative n_exp leaves the expectation to
  // the encoder model; otherwise exp_bytes holds n_exp bytes, first one leftmost.
  typedef struct packed {
    row_kind_e         kind;
    logic [7:0]        data;
    logic              last;
    int                n_exp;
    logic [47:0]       exp_bytes;
    logic [31:0]       arg;
    logic [PaddrW-1:0] addr;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       item_end;
    logic       block_end;
  } coded_word_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [7:0]        data_byte_i;
  logic              last_in_block_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [7:0]        out_byte_o;
  logic              out_item_end_o;
  logic              out_block_end_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [PdataW-1:0] pwdata;
  logic [PdataW-1:0] prdata;
  logic              pready;

  // Encoder model state
  logic        model_two;
  logic [7:0]  model_val;
  logic [15:0] model_len;
  logic        model_open;

  logic [7:0]  item_bytes[$];
  coded_word_t awaited_words[$];
  stim_row_t   stim_table[$];

  logic idle_on = 1'b0;
  int   hold_cnt = 0;
  int   mismatches = 0;
  int   words_sent = 0;
  int   bytes_checked = 0;
  int   reg_writes = 0;

  rle_byte_stream_encoder uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .data_byte_i     (data_byte_i),
    .last_in_block_i (last_in_block_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_byte_o      (out_byte_o),
    .out_item_end_o  (out_item_end_o),
    .out_block_end_o (out_block_end_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Appends the open run as count byte(s) then data byte.
  function automatic void put_run();
    logic [15:0] cnt;
    if (model_two) begin
      item_bytes.push_back(model_len[7:0]);
      item_bytes.push_back(model_len[15:8]);
    end else begin
      cnt = (model_len > MaxCountOne) ? MaxCountOne : model_len;
      item_bytes.push_back(cnt[7:0]);
    end
    item_bytes.push_back(model_val);
  endfunction

  function automatic void encode_word(input logic [7:0] b, input logic l);
    logic [15:0] top;
    top = model_two ? MaxCountTwo : MaxCountOne;
    item_bytes = {};
    if (model_open && b == model_val && model_len < top) begin
      model_len = model_len + 16'd1;
    end else begin
      if (model_open) put_run();
      model_val  = b;
      model_len  = 16'd1;
      model_open = 1'b1;
    end
    if (l) begin
      put_run();
      model_open = 1'b0;
      model_val  = '0;
      model_len  = '0;
    end
  endfunction

  function automatic void add_row(input row_kind_e k, input logic [7:0] d, input logic l,
                                  input int n, input logic [47:0] e,
                                  input logic [31:0] arg, input logic [PaddrW-1:0] a);
    stim_row_t r;
    r.kind = k;
    r.data = d;
    r.last = l;
    r.n_exp = n;
    r.exp_bytes = e;
    r.arg = arg;
    r.addr = a;
    stim_table.push_back(r);
  endfunction

  // Offers one word and waits for it to be taken. The expectation is queued before
  // the word is offered, so the monitor can never see its output first.
  task automatic send_word(input logic [7:0] b, input logic l, input int n_typed,
                           input logic [47:0] typed_bytes);
    int gap;
    int n;
    coded_word_t w;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    encode_word(b, l);
    if (n_typed >= 0) begin
      item_bytes = {};
      for (int k = 0; k < n_typed; k++)
        item_bytes.push_back(typed_bytes[8*(n_typed-1-k) +: 8]);
    end
    n = item_bytes.size();
    for (int k = 0; k < n; k++) begin
      w.data      = item_bytes[k];
      w.item_end  = (k == n - 1);
      w.block_end = l && (k == n - 1);
      awaited_words.push_back(w);
    end
    data_byte_i     <= b;
    last_in_block_i <= l;
    in_valid_i      <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
  endtask

  // Writes a register once the encoder has gone quiet, then reads the mode back.
  task automatic set_mode_reg(input logic [PaddrW-1:0] a, input logic [31:0] v);
    in_valid_i <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (a[2] == RegCountMode) model_two = v[0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= AddrMode;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[0] !== model_two) begin
      $display("%0t: mode read-back mismatch: expected %b, got %b", $time, model_two,
               prdata[0]);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    reg_writes++;
  endtask

  // Receiver back-pressure in bursts.
  always @(posedge clk_i) begin
    if (hold_cnt > 1) begin
      hold_cnt <= hold_cnt - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      hold_cnt    <= $urandom_range(1, 7);
      out_ready_i <= 1'b0;
    end else begin
      hold_cnt    <= 0;
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : word_check
    coded_word_t head;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_words.size() == 0) begin
        $display("%0t: unexpected output word: got byte %h item_end %b block_end %b",
                 $time, out_byte_o, out_item_end_o, out_block_end_o);
        mismatches++;
      end else begin
        head = awaited_words.pop_front();
        if (out_byte_o !== head.data || out_item_end_o !== head.item_end ||
            out_block_end_o !== head.block_end) begin
          $display("%0t: output mismatch: expected %h/%b/%b, got %h/%b/%b", $time,
                   head.data, head.item_end, head.block_end,
                   out_byte_o, out_item_end_o, out_block_end_o);
          mismatches++;
        end
        bytes_checked++;
      end
    end
  end

  initial begin
    int rand_words;
    int n_runs;
    int len;
    logic [7:0] pool [4];
    logic [7:0] val;
    logic l;

    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    data_byte_i     = '0;
    last_in_block_i = 1'b0;
    out_ready_i     = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    model_two  = 1'b1;
    model_val  = '0;
    model_len  = '0;
    model_open = 1'b0;

    // Two-byte counts out of reset.
    add_row(RowWord, 8'h00, 1'b1, 3, 48'h01_00_00, '0, '0);
    add_row(RowWord, 8'hFF, 1'b0, 0, '0, '0, '0);
    add_row(RowWord, 8'hFF, 1'b0, 0, '0, '0, '0);
    add_row(RowWord, 8'h00, 1'b0, 3, 48'h02_00_FF, '0, '0);
    add_row(RowWord, 8'hA5, 1'b1, 6, 48'h01_00_00_01_00_A5, '0, '0);
    add_row(RowWord, 8'h5A, 1'b0, -1, '0, '0, '0);
    add_row(RowWord, 8'h5A, 1'b0, -1, '0, '0, '0);
    add_row(RowWord, 8'h5A, 1'b1, 3, 48'h03_00_5A, '0, '0);
    add_row(RowWord, 8'h80, 1'b0, -1, '0, '0, '0);
    add_row(RowWord, 8'h01, 1'b0, -1, '0, '0, '0);
    add_row(RowWord, 8'h7F, 1'b0, -1, '0, '0, '0);
    add_row(RowWord, 8'hFE, 1'b1, -1, '0, '0, '0);
    // Drop to one-byte counts under a 256-long run; only bit 0 of the write counts.
    add_row(RowRun,  8'h3C, 1'b0, -1, '0, 32'd256, '0);
    add_row(RowReg,  8'h00, 1'b0, -1, '0, 32'hFFFF_FFFE, AddrMode);
    add_row(RowWord, 8'h3C, 1'b0, 2, 48'hFF_3C, '0, '0);
    add_row(RowWord, 8'h3C, 1'b1, 2, 48'h02_3C, '0, '0);
    add_row(RowReg,  8'h00, 1'b0, -1, '0, 32'h0000_0001, AddrSpare);
    add_row(RowRun,  8'h77, 1'b0, -1, '0, 32'd255, '0);
    add_row(RowWord, 8'h77, 1'b0, 2, 48'hFF_77, '0, '0);
    add_row(RowWord, 8'h00, 1'b1, 4, 48'h01_77_01_00, '0, '0);
    add_row(RowWord, 8'h10, 1'b0, -1, '0, '0, '0);
    add_row(RowWord, 8'h20, 1'b1, -1, '0, '0, '0);
    // Mode flipped while a short run is open.
    add_row(RowReg,  8'h00, 1'b0, -1, '0, 32'h0000_0001, AddrMode);
    add_row(RowWord, 8'h42, 1'b0, 0, '0, '0, '0);
    add_row(RowReg,  8'h00, 1'b0, -1, '0, 32'h0000_0000, AddrMode);
    add_row(RowWord, 8'h42, 1'b1, 2, 48'h02_42, '0, '0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_on = 1'b1;
    foreach (stim_table[i]) begin
      case (stim_table[i].kind)
        RowWord: begin
          send_word(stim_table[i].data, stim_table[i].last, stim_table[i].n_exp,
                    stim_table[i].exp_bytes);
        end
        RowRun: begin
          // Long runs go through without gaps to keep the run short.
          idle_on = 1'b0;
          repeat (stim_table[i].arg) send_word(stim_table[i].data, 1'b0, -1, '0);
          idle_on = 1'b1;
        end
        default: begin
          set_mode_reg(stim_table[i].addr, stim_table[i].arg);
        end
      endcase
    end

    // Mostly well-formed blocks of runs drawn from a small pool of values, so that
    // neighbouring runs sometimes merge; the rest is loose noise.
    rand_words = 0;
    while (rand_words < RandWords) begin
      idle_on = (rand_words < RandWords - 20) && ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 2) == 0) begin
        if ($urandom_range(0, 5) == 0) set_mode_reg(AddrSpare, $urandom);
        else set_mode_reg(AddrMode, $urandom);
      end
      if ($urandom_range(0, 3) != 0) begin
        for (int k = 0; k < 4; k++) pool[k] = 8'($urandom);
        n_runs = $urandom_range(1, 6);
        for (int r = 0; r < n_runs; r++) begin
          if ($urandom_range(0, 1) == 0) val = pool[$urandom_range(0, 3)];
          else val = 8'($urandom);
          if ($urandom_range(0, 4) == 0) len = $urandom_range(5, 40);
          else len = $urandom_range(1, 4);
          for (int k = 0; k < len; k++) begin
            send_word(val, (r == n_runs - 1) && (k == len - 1), -1, '0);
            rand_words++;
          end
        end
      end else begin
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
          val = 8'($urandom);
          l = ($urandom_range(0, 3) == 0);
          send_word(val, l, -1, '0);
          rand_words++;
        end
      end
    end

    idle_on = 1'b0;
    in_valid_i <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    $display("Run covered %0d input words, %0d register writes, %0d output words checked.",
             words_sent, reg_writes, bytes_checked);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d output words still awaited.", awaited_words.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
